// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the mouse packet tracker RTL.
// Included by bare name; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/ps2mt_pkg.sv -----
// Types, constants and helpers for the mouse packet tracker.
// Used by every module of the block; depends on nothing.
package ps2mt_pkg;

   // Cursor reset position.
   localparam logic [11:0] START_X = 12'd512;
   localparam logic [11:0] START_Y = 12'd384;

   // Configuration reset values.
   localparam logic [3:0]  SENS_RESET    = 4'd1;
   localparam logic [11:0] X_LIMIT_RESET = 12'd1023;
   localparam logic [11:0] Y_LIMIT_RESET = 12'd767;

   // Header byte bit positions.
   localparam int HDR_LEFT_BIT   = 0;
   localparam int HDR_RIGHT_BIT  = 1;
   localparam int HDR_MIDDLE_BIT = 2;
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_XSIGN_BIT  = 4;
   localparam int HDR_YSIGN_BIT  = 5;

   // Packet queue between the assembler and the cursor unit.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SENSITIVITY = 2'd0,
      CSR_X_LIMIT     = 2'd1,
      CSR_Y_LIMIT     = 2'd2
   } csr_index_type;

   // Live configuration seen by the cursor unit.
   typedef struct packed {
      logic [3:0]  sensitivity;
      logic [11:0] x_limit;
      logic [11:0] y_limit;
   } cfg_type;

   // One assembled three-byte packet.
   typedef struct packed {
      logic [7:0] header;
      logic [7:0] x_move;
      logic [7:0] y_move;
   } pkt_type;

   // Queue status toward the producer and consumer.
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // Clamp a signed position into [0, lim].
   function automatic logic [11:0] clamp_pos(input logic signed [13:0] v,
                                             input logic [11:0] lim);
      logic [11:0] res;
      if (v[13]) begin
         res = 12'd0;
      end else if (v[12:0] > {1'b0, lim}) begin
         res = lim;
      end else begin
         res = v[11:0];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/ps2mt_front.sv -----
// Packet assembler: hunts for a header byte and gathers three-byte packets.
// Depends on ps2mt_pkg; pushes whole packets into ps2mt_fifo.
module ps2mt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   input  ps2mt_pkg::fifo_stat_type fifo_stat,
   output logic                    push,
   output ps2mt_pkg::pkt_type      push_pkt
);

   logic       in_packet_ff, in_packet_in;
   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] x_move_ff, x_move_in;
   logic       accept;

   // A byte is taken whenever the queue has room for a finished packet.
   assign req_ready = !fifo_stat.full;
   assign accept    = req_valid && req_ready;

   // Packet framing. Any index other than one inside a packet ends it.
   always_comb begin
      in_packet_in  = in_packet_ff;
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      x_move_in     = x_move_ff;
      push          = 1'b0;
      if (accept) begin
         if (!in_packet_ff) begin
            if (req_rx_byte[ps2mt_pkg::HDR_SYNC_BIT]) begin
               header_in     = req_rx_byte;
               in_packet_in  = 1'b1;
               byte_index_in = 2'd1;
            end
         end else if (byte_index_ff == 2'd1) begin
            x_move_in     = req_rx_byte;
            byte_index_in = 2'd2;
         end else begin
            in_packet_in  = 1'b0;
            byte_index_in = 2'd0;
            push          = 1'b1;
         end
      end
   end

   // The completed packet goes straight into the queue.
   always_comb begin
      push_pkt.header = header_ff;
      push_pkt.x_move = x_move_ff;
      push_pkt.y_move = req_rx_byte;
   end

   // Framing state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff  <= 1'b0;
         byte_index_ff <= 2'd0;
      end else begin
         in_packet_ff  <= in_packet_in;
         byte_index_ff <= byte_index_in;
      end
   end

   // Packet bytes held while the rest arrives.
   always_ff @(posedge clock) begin
      header_ff <= header_in;
      x_move_ff <= x_move_in;
   end

endmodule

// ----- hw/rtl/ps2mt_fifo.sv -----
// Small packet queue between the assembler and the cursor unit.
// Depends on ps2mt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ps2mt_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ps2mt_pkg::pkt_type       push_pkt,
   input  logic                     pop,
   output ps2mt_pkg::pkt_type       pop_pkt,
   output ps2mt_pkg::fifo_stat_type stat
);

   ps2mt_pkg::pkt_type                   mem_ff [ps2mt_pkg::FIFO_DEPTH];
   logic [ps2mt_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ps2mt_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ps2mt_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;

   localparam logic [ps2mt_pkg::FIFO_PTR_W-1:0] LastPtr =
      ps2mt_pkg::FIFO_PTR_W'(ps2mt_pkg::FIFO_DEPTH - 1);
   localparam logic [ps2mt_pkg::FIFO_CNT_W-1:0] FullCount =
      ps2mt_pkg::FIFO_CNT_W'(ps2mt_pkg::FIFO_DEPTH);

   // Status and head of queue.
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FullCount);
   assign pop_pkt    = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Packet storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   `ASSERT_NEVER(a_no_push_when_full, clock, reset, push && stat.full && !pop)
   `ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > FullCount)

endmodule

// ----- hw/rtl/ps2mt_back.sv -----
// Cursor unit: scales packet deltas, moves and clamps the cursor, holds the result.
// Depends on ps2mt_pkg and assert_macros.svh; drains ps2mt_fifo.
`include "assert_macros.svh"
module ps2mt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ps2mt_pkg::cfg_type       cfg,
   input  ps2mt_pkg::fifo_stat_type fifo_stat,
   input  ps2mt_pkg::pkt_type       pkt,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [11:0]              rsp_pos_x,
   output logic [11:0]              rsp_pos_y,
   output logic signed [8:0]        rsp_delta_x,
   output logic signed [8:0]        rsp_delta_y,
   output logic                     rsp_left_button,
   output logic                     rsp_right_button,
   output logic                     rsp_middle_button
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        cursor_x_ff, cursor_x_in;
   logic [11:0]        cursor_y_ff, cursor_y_in;
   logic signed [8:0]  delta_x_ff, delta_y_ff;
   logic [2:0]         buttons_ff;
   logic signed [8:0]  dx, dy;
   logic signed [4:0]  sens;
   logic signed [12:0] prod_x, prod_y;
   logic signed [13:0] next_x, next_y;

   // Take a packet when the output register is empty or being emptied.
   assign pop = !fifo_stat.empty && (!rsp_valid_ff || rsp_ready);

   // Nine-bit deltas from the header sign bits, scaled by sensitivity.
   always_comb begin
      dx     = $signed({pkt.header[ps2mt_pkg::HDR_XSIGN_BIT], pkt.x_move});
      dy     = $signed({pkt.header[ps2mt_pkg::HDR_YSIGN_BIT], pkt.y_move});
      sens   = $signed({1'b0, cfg.sensitivity});
      prod_x = 13'(dx) * 13'(sens);
      prod_y = 13'(dy) * 13'(sens);
      next_x = $signed({2'b00, cursor_x_ff}) + $signed({prod_x[12], prod_x});
      next_y = $signed({2'b00, cursor_y_ff}) - $signed({prod_y[12], prod_y});
   end

   // Cursor and output valid update.
   always_comb begin
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         cursor_x_in  = ps2mt_pkg::clamp_pos(next_x, cfg.x_limit);
         cursor_y_in  = ps2mt_pkg::clamp_pos(next_y, cfg.y_limit);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cursor_x_ff  <= ps2mt_pkg::START_X;
         cursor_y_ff  <= ps2mt_pkg::START_Y;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
      end
   end

   // Result payload, loaded with each packet taken.
   always_ff @(posedge clock) begin
      if (pop) begin
         delta_x_ff <= dx;
         delta_y_ff <= dy;
         buttons_ff <= {pkt.header[ps2mt_pkg::HDR_MIDDLE_BIT],
                        pkt.header[ps2mt_pkg::HDR_RIGHT_BIT],
                        pkt.header[ps2mt_pkg::HDR_LEFT_BIT]};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = cursor_x_ff;
   assign rsp_pos_y         = cursor_y_ff;
   assign rsp_delta_x       = delta_x_ff;
   assign rsp_delta_y       = delta_y_ff;
   assign rsp_left_button   = buttons_ff[0];
   assign rsp_right_button  = buttons_ff[1];
   assign rsp_middle_button = buttons_ff[2];

   `ASSERT_NEXT(a_pop_gives_result, clock, reset, pop, rsp_valid_ff)
   `ASSERT_NEXT(a_cursor_x_holds, clock, reset, !pop, $stable(cursor_x_ff))

endmodule

// ----- hw/rtl/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: configuration registers and wiring.
// Depends on ps2mt_pkg, ps2mt_front, ps2mt_fifo and ps2mt_back.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    req_rx_byte
//   rsp      rsp_valid/rsp_ready    rsp_pos_x/y, rsp_delta_x/y, rsp_*_button
//   csr      csr_valid/csr_ready    csr_index, csr_wdata
//
// One byte is taken per cycle while the two-entry packet queue has room.
// The cursor unit finishes one packet per cycle unless its output stalls; a
// finished packet is queued, then loaded into the result register when taken.
// Reset clears framing, queue and output valid and puts the cursor at its start.
// A stalled result output backs up into the queue, then stalls byte intake.
module ps2_mouse_packet_tracker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_pos_x,
   output logic [11:0]        rsp_pos_y,
   output logic signed [8:0]  rsp_delta_x,
   output logic signed [8:0]  rsp_delta_y,
   output logic               rsp_left_button,
   output logic               rsp_right_button,
   output logic               rsp_middle_button,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   ps2mt_pkg::cfg_type       cfg_ff, cfg_in;
   ps2mt_pkg::fifo_stat_type fifo_stat;
   ps2mt_pkg::pkt_type       push_pkt, pop_pkt;
   logic                     push, pop;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ps2mt_pkg::csr_index_type'(csr_index))
            ps2mt_pkg::CSR_SENSITIVITY: cfg_in.sensitivity = csr_wdata[3:0];
            ps2mt_pkg::CSR_X_LIMIT:     cfg_in.x_limit     = csr_wdata;
            ps2mt_pkg::CSR_Y_LIMIT:     cfg_in.y_limit     = csr_wdata;
            default:                    cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity <= ps2mt_pkg::SENS_RESET;
         cfg_ff.x_limit     <= ps2mt_pkg::X_LIMIT_RESET;
         cfg_ff.y_limit     <= ps2mt_pkg::Y_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Byte framing.
   ps2mt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_pkt    (push_pkt)
   );

   // Packet queue.
   ps2mt_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .pop_pkt  (pop_pkt),
      .stat     (fifo_stat)
   );

   // Cursor update and result register.
   ps2mt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .fifo_stat         (fifo_stat),
      .pkt               (pop_pkt),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button)
   );

endmodule

// ----- bench/ps2_mouse_packet_tracker_test.sv -----
// Self-checking testbench for the PS/2 mouse packet tracker: byte driver, report monitor,
// cursor predictor and a register sweep over sensitivity and screen limits.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker.
module ps2_mouse_packet_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_SPAN    = 256;
   localparam int LATENCY_TAIL = 12;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 120;
   localparam logic [7:0] SYNC_MASK = 8'h01 << ps2mt_pkg::HDR_SYNC_BIT;

   // Receiver pacing modes.
   typedef enum int {
      DRAIN_FREE,
      DRAIN_HALF,
      DRAIN_SPARSE,
      DRAIN_MOSTLY
   } drain_mode_type;

   // One expected cursor report.
   typedef struct {
      logic [11:0]       pos_x;
      logic [11:0]       pos_y;
      logic signed [8:0] delta_x;
      logic signed [8:0] delta_y;
      logic              left;
      logic              right;
      logic              middle;
   } cursor_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [11:0]       rsp_pos_x;
   logic [11:0]       rsp_pos_y;
   logic signed [8:0] rsp_delta_x;
   logic signed [8:0] rsp_delta_y;
   logic              rsp_left_button;
   logic              rsp_right_button;
   logic              rsp_middle_button;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = ps2mt_pkg::CSR_SENSITIVITY;
   logic [11:0]       csr_wdata = 12'd0;

   // Byte stream waiting for the driver and reports waiting for the monitor.
   logic [7:0]        byte_backlog [$];
   cursor_report_type awaited_reports [$];

   // Predicted tracker state and configuration.
   logic [3:0]  cfg_sens = ps2mt_pkg::SENS_RESET;
   logic [11:0] cfg_xlim = ps2mt_pkg::X_LIMIT_RESET;
   logic [11:0] cfg_ylim = ps2mt_pkg::Y_LIMIT_RESET;
   logic        hdr_held = 1'b0;
   logic        xmove_held = 1'b0;
   logic [7:0]  hdr_byte = 8'd0;
   logic [7:0]  xmove_byte = 8'd0;
   logic [11:0] cur_x = ps2mt_pkg::START_X;
   logic [11:0] cur_y = ps2mt_pkg::START_Y;

   // Framing as seen by the stimulus generator, so each phase ends on a packet boundary.
   bit gen_in_pkt = 1'b0;
   int gen_pos = 0;

   // Handshake bookkeeping and run statistics.
   logic req_fire = 1'b0;
   int   gap_left = 0;
   int   burst_left = 1;
   int   hold_asked = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   mode_left = 0;
   drain_mode_type drain_mode = DRAIN_FREE;
   int   faults = 0;
   int   bytes_taken = 0;
   int   strays_dropped = 0;
   int   reports_checked = 0;
   int   reg_writes = 0;

   ps2_mouse_packet_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Free-running clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Clamp a signed cursor coordinate into the screen range.
   function automatic logic [11:0] clamp_coord(input int v, input logic [11:0] lim);
      if (v < 0) return 12'd0;
      if (v > int'(lim)) return lim;
      return v[11:0];
   endfunction

   // Advance the predicted framing by one accepted byte; a completed packet moves the cursor.
   task automatic track_byte(input logic [7:0] b);
      cursor_report_type rep;
      int dx;
      int dy;
      if (!hdr_held) begin
         if (b[ps2mt_pkg::HDR_SYNC_BIT]) begin
            hdr_byte = b;
            hdr_held = 1'b1;
            xmove_held = 1'b0;
         end else begin
            strays_dropped++;
         end
      end else if (!xmove_held) begin
         xmove_byte = b;
         xmove_held = 1'b1;
      end else begin
         hdr_held = 1'b0;
         xmove_held = 1'b0;
         dx = hdr_byte[ps2mt_pkg::HDR_XSIGN_BIT] ? int'(xmove_byte) - BYTE_SPAN
                                                 : int'(xmove_byte);
         dy = hdr_byte[ps2mt_pkg::HDR_YSIGN_BIT] ? int'(b) - BYTE_SPAN : int'(b);
         cur_x = clamp_coord(int'(cur_x) + dx * int'(cfg_sens), cfg_xlim);
         cur_y = clamp_coord(int'(cur_y) - dy * int'(cfg_sens), cfg_ylim);
         rep.pos_x = cur_x;
         rep.pos_y = cur_y;
         rep.delta_x = dx[8:0];
         rep.delta_y = dy[8:0];
         rep.left = hdr_byte[ps2mt_pkg::HDR_LEFT_BIT];
         rep.right = hdr_byte[ps2mt_pkg::HDR_RIGHT_BIT];
         rep.middle = hdr_byte[ps2mt_pkg::HDR_MIDDLE_BIT];
         awaited_reports.push_back(rep);
      end
   endtask

   // Compare one report field and log any difference.
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         faults++;
      end
   endtask

   // Check a completed report transfer against the oldest prediction.
   task automatic check_report();
      cursor_report_type want;
      if (awaited_reports.size() == 0) begin
         $error("report transfer with no packet outstanding (pos_x %0d, pos_y %0d)",
                rsp_pos_x, rsp_pos_y);
         faults++;
      end else begin
         want = awaited_reports.pop_front();
         compare_field("pos_x", want.pos_x, rsp_pos_x);
         compare_field("pos_y", want.pos_y, rsp_pos_y);
         compare_field("delta_x", want.delta_x, rsp_delta_x);
         compare_field("delta_y", want.delta_y, rsp_delta_y);
         compare_field("left_button", want.left, rsp_left_button);
         compare_field("right_button", want.right, rsp_right_button);
         compare_field("middle_button", want.middle, rsp_middle_button);
         reports_checked++;
      end
   endtask

   // Monitor: sample both channels at the rising edge.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_byte(req_rx_byte);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            check_report();
         end
      end
   end

   // Byte driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin : byte_driver
      logic       next_valid;
      logic [7:0] next_byte;
      next_valid = req_valid;
      next_byte = req_rx_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (byte_backlog.size() > 0) begin
            next_valid = 1'b1;
            next_byte = byte_backlog.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= next_valid;
      req_rx_byte <= next_byte;
   end

   // Report receiver: its own pacing pattern, plus a long hold-off on request.
   always @(negedge clock) begin : report_receiver
      logic next_ready;
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(10, 80);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else begin
         case (drain_mode)
            DRAIN_FREE:   next_ready = 1'b1;
            DRAIN_HALF:   next_ready = 1'($urandom_range(0, 1));
            DRAIN_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
            default:      next_ready = ($urandom_range(0, 7) != 0);
         endcase
      end
      rsp_ready <= next_ready;
   end

   // Queue one byte for the driver; returns 1 unless the tracker will just drop it.
   function automatic int offer_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
      if (!gen_in_pkt) begin
         if (!b[ps2mt_pkg::HDR_SYNC_BIT]) return 0;
         gen_in_pkt = 1'b1;
         gen_pos = 1;
      end else if (gen_pos == 1) begin
         gen_pos = 2;
      end else begin
         gen_in_pkt = 1'b0;
         gen_pos = 0;
      end
      return 1;
   endfunction

   // Movement byte, leaning toward the sign and magnitude extremes.
   function automatic logic [7:0] pick_move();
      logic [7:0] edges [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Screen limit, with the full range and typical screen sizes favored.
   function automatic logic [11:0] pick_limit();
      case ($urandom_range(0, 3))
         0:       return 12'd4095;
         1:       return 12'($urandom_range(200, 1200));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Mostly well-formed packets, with stray noise and cut-short packets mixed in.
   task automatic queue_traffic(input int n_items);
      int counted;
      int pick;
      counted = 0;
      while (counted < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            counted += offer_byte(8'($urandom_range(0, 255)));
         end else if (pick < 12) begin
            counted += offer_byte(8'($urandom_range(0, 255)) | SYNC_MASK);
            if ($urandom_range(0, 1) == 1) counted += offer_byte(pick_move());
         end else begin
            counted += offer_byte(8'($urandom_range(0, 255)) | SYNC_MASK);
            counted += offer_byte(pick_move());
            counted += offer_byte(pick_move());
         end
      end
      // Finish any open packet so the next register write lands between packets.
      while (gen_in_pkt) void'(offer_byte(pick_move()));
   endtask

   // Wait until every byte has been taken and every report has come back.
   task automatic settle();
      int waited;
      waited = 0;
      while (!(byte_backlog.size() == 0 && !req_valid && awaited_reports.size() == 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT) begin
         $error("%0d reports still outstanding after drain limit", awaited_reports.size());
         faults++;
      end
      repeat (LATENCY_TAIL) @(posedge clock);
   endtask

   // One register transfer; the predicted configuration follows at acceptance.
   task automatic write_reg(input ps2mt_pkg::csr_index_type idx, input logic [11:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         ps2mt_pkg::CSR_SENSITIVITY: cfg_sens = val[3:0];
         ps2mt_pkg::CSR_X_LIMIT:     cfg_xlim = val;
         default:                    cfg_ylim = val;
      endcase
      reg_writes++;
   endtask

   // Drain, reprogram all three registers, then run a stretch of traffic.
   task automatic run_phase(input logic [3:0] sens, input logic [11:0] xlim,
                            input logic [11:0] ylim, input bit squeeze);
      settle();
      write_reg(ps2mt_pkg::CSR_SENSITIVITY, {8'd0, sens});
      write_reg(ps2mt_pkg::CSR_X_LIMIT, xlim);
      write_reg(ps2mt_pkg::CSR_Y_LIMIT, ylim);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (squeeze) hold_asked++;
      queue_traffic(PHASE_ITEMS);
   endtask

   // Stimulus sequence and verdict.
   initial begin
      logic [7:0] opening [] = '{
         8'h00, 8'hF7,                // stray bytes while hunting
         8'h08, 8'h00, 8'h00,         // header alone, no motion
         8'h0F, 8'hFF, 8'hFF,         // all buttons, largest positive deltas
         8'h38, 8'h00, 8'h00,         // both signs set, most negative deltas
         8'hF8, 8'h01, 8'hFF,         // overflow bits set, signs set
         8'h09, 8'h7F, 8'h80,         // left button, mid-range moves
         8'hFF, 8'hAA, 8'h55,         // every header bit set
         8'h0E, 8'h00, 8'h00          // stray-looking zero data inside a packet
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset configuration.
      foreach (opening[i]) void'(offer_byte(opening[i]));

      // Register sweep: extremes first, then random settings.
      run_phase(4'd15, 12'd4095, 12'd4095, 1'b0);
      run_phase(4'd0, 12'd100, 12'd50, 1'b0);
      run_phase(4'd15, 12'd0, 12'd0, 1'b0);
      run_phase(4'd1, 12'd1023, 12'd767, 1'b1);
      run_phase(4'd3, 12'd4095, 12'd0, 1'b0);
      repeat (4) begin
         run_phase(4'($urandom_range(0, 15)), pick_limit(), pick_limit(), 1'b0);
      end

      settle();
      $display("Run covered %0d bytes (%0d strays dropped) and %0d cursor reports,",
               bytes_taken, strays_dropped, reports_checked);
      $display("across %0d register writes with long output stalls.", reg_writes);
      if (faults == 0) begin
         $display("ps2_mouse_packet_tracker: match");
      end else begin
         $display("ps2_mouse_packet_tracker: mismatch");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_400_000;
      $display("ps2_mouse_packet_tracker: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ps2mt_pkg.sv
hw/rtl/ps2mt_front.sv
hw/rtl/ps2mt_fifo.sv
hw/rtl/ps2mt_back.sv
hw/rtl/ps2_mouse_packet_tracker.sv
bench/ps2_mouse_packet_tracker_test.sv
